@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SWE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SWE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/swe_pkg.sv @@
`default_nettype none
package swe_pkg;

   localparam int DEF_WINDOW     = 4;
   localparam int DEF_MAX_SEQ    = 7;
   localparam int DEF_TIMER_BITS = 16;

   localparam int CFG_W      = 16;
   localparam int RESULT_CAP = 8;

   localparam logic [CFG_W-1:0] FRAME_TIMEOUT_RST = 16'd100;
   localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST   = 16'd50;

   // Register indexes of the write port.
   localparam logic CSR_FRAME_TIMEOUT = 1'b0;
   localparam logic CSR_ACK_TIMEOUT   = 1'b1;

   // Event codes.
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_SEND  = 2'd1;
   localparam logic [1:0] REQ_FRAME = 2'd2;
   localparam logic [1:0] REQ_START = 2'd3;

   // Arrived frame kinds.
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_NAK  = 2'd2;

   // Result actions.
   localparam logic [2:0] ACT_DATA    = 3'd0;
   localparam logic [2:0] ACT_ACK     = 3'd1;
   localparam logic [2:0] ACT_NAK     = 3'd2;
   localparam logic [2:0] ACT_DELIVER = 3'd3;
   localparam logic [2:0] ACT_REFUSE  = 3'd4;

   typedef struct packed {
      logic [1:0] req_type;
      logic [1:0] frame_kind;
      logic [2:0] frame_seq;
      logic [2:0] frame_ack;
      logic       checksum_bad;
   } swe_req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [2:0] out_seq;
      logic [2:0] out_ack;
      logic [1:0] buffer_slot;
      logic       last_result;
   } swe_rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_TICK_SLOT,
      OP_TICK_ACK,
      OP_SEND,
      OP_DATA_FRONT,
      OP_DELIVER,
      OP_NAK_RESEND,
      OP_RELEASE,
      OP_BAD_NAK,
      OP_SESSION,
      OP_FINISH
   } swe_op_type;

   typedef struct packed {
      swe_op_type op;
   } swe_cmd_type;

   typedef struct packed {
      logic       can_emit;
      logic       flush_done;
      logic       deliver_more;
      logic       release_more;
      logic       tick_last;
      logic [1:0] req_type;
      logic [1:0] frame_kind;
      logic       checksum_bad;
   } swe_status_type;

endpackage
`default_nettype wire

@@ sv/selective_repeat_window_engine.sv @@
// Channel  Direction  Handshake              Word
// req      in         req_valid / req_ready  swe_req_type: one event
// rsp      out        rsp_valid / rsp_ready  swe_rsp_type: one command
// csr      in         csr_we                 csr_index, csr_wdata
//
// The IDLE and DISPATCH states accept and decode an event; each walk then
// moves one step a cycle while the holding stage can take a word: a tick
// visits the WINDOW slots and then the ack timer, an arrived frame delivers
// and releases one frame a cycle, and the FINISH state flushes the final
// word. Reset is synchronous and active high; a full holding stage stalls
// the sequencer on a busy rsp port.
`default_nettype none
`include "assert_macros.svh"
module selective_repeat_window_engine import swe_pkg::*; #(
   parameter int WINDOW     = DEF_WINDOW,
   parameter int MAX_SEQ    = DEF_MAX_SEQ,
   parameter int TIMER_BITS = DEF_TIMER_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire swe_req_type      req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output swe_rsp_type           rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   swe_cmd_type    cmd;
   swe_status_type st;

   swe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   swe_dp #(
      .WINDOW     (WINDOW),
      .MAX_SEQ    (MAX_SEQ),
      .TIMER_BITS (TIMER_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Back in idle, nothing may linger in the holding stage.
   `SWE_ASSERT_NOW(a_idle_flushed, clock, reset, req_ready, st.flush_done, "word left in holding stage")
   // A word still shown while idle is the final one of its event.
   `SWE_ASSERT_NOW(a_idle_last, clock, reset, req_ready && rsp_valid, rsp_data.last_result, "idle word not marked last")
   // An accepted event keeps the input closed in the following cycle.
   `SWE_ASSERT_NEXT(a_one_event, clock, reset, req_valid && req_ready, !req_ready, "second event taken too early")

endmodule
`default_nettype wire

@@ sv/swe_dp.sv @@
`default_nettype none
module swe_dp import swe_pkg::*; #(
   parameter int WINDOW     = DEF_WINDOW,
   parameter int MAX_SEQ    = DEF_MAX_SEQ,
   parameter int TIMER_BITS = DEF_TIMER_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire swe_cmd_type      cmd,
   output swe_status_type        st,
   input  wire swe_req_type      req_data,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output swe_rsp_type           rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   localparam int SEQ_SPACE = MAX_SEQ + 1;
   localparam int SEQ_W     = (MAX_SEQ > 0) ? $clog2(SEQ_SPACE) : 1;
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int TB        = TIMER_BITS;
   localparam logic [SEQ_W-1:0]  SEQ_MAX   = SEQ_W'(MAX_SEQ);
   localparam logic [SEQ_W-1:0]  TF_RST    = SEQ_W'(WINDOW % SEQ_SPACE);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);
   localparam logic [TB+CFG_W-1:0] TMAX    = {{CFG_W{1'b0}}, {TB{1'b1}}};

   // Constant lookup tables for the modulo reductions.
   logic [SLOT_W-1:0] slot_lut [SEQ_SPACE];
   logic [SEQ_W-1:0]  seq_lut  [8];

   genvar g;
   for (g = 0; g < SEQ_SPACE; g++) begin : g_slot
      assign slot_lut[g] = SLOT_W'(g % WINDOW);
   end
   for (g = 0; g < 8; g++) begin : g_seq
      assign seq_lut[g] = SEQ_W'(g % SEQ_SPACE);
   end

   logic [CFG_W-1:0]  cfg_frame_ff, cfg_frame_in;
   logic [CFG_W-1:0]  cfg_ack_ff, cfg_ack_in;
   swe_req_type       req_ff, req_in;
   logic [SEQ_W-1:0]  ae_ff, ae_in;
   logic [SEQ_W-1:0]  nts_ff, nts_in;
   logic [SEQ_W-1:0]  fe_ff, fe_in;
   logic [SEQ_W-1:0]  tf_ff, tf_in;
   logic [CNT_W-1:0]  outst_ff, outst_in;
   logic              nak_ok_ff, nak_ok_in;
   logic [WINDOW-1:0] marks_ff, marks_in;
   logic [SEQ_W-1:0]  slot_seq_ff [WINDOW];
   logic [SEQ_W-1:0]  slot_seq_in [WINDOW];
   logic [TB-1:0]     timers_ff [WINDOW];
   logic [TB-1:0]     timers_in [WINDOW];
   logic [TB-1:0]     ack_tmr_ff, ack_tmr_in;
   logic [SLOT_W-1:0] walk_ff, walk_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              pend_valid_ff, pend_valid_in;
   swe_rsp_type       pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   swe_rsp_type       rsp_ff, rsp_in;

   function automatic logic [2:0] to3(input logic [SEQ_W-1:0] x);
      logic [SEQ_W+2:0] w;
      w = {3'b000, x};
      return w[2:0];
   endfunction

   function automatic logic [1:0] to2(input logic [SLOT_W-1:0] x);
      logic [SLOT_W+1:0] w;
      w = {2'b00, x};
      return w[1:0];
   endfunction

   function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] x);
      return (x == SEQ_MAX) ? '0 : x + 1'b1;
   endfunction

   function automatic logic in_win(input logic [SEQ_W-1:0] lo,
                                   input logic [SEQ_W-1:0] x,
                                   input logic [SEQ_W-1:0] hi);
      return (x >= lo && x < hi) || (hi < lo && (x >= lo || x < hi));
   endfunction

   function automatic logic [TB-1:0] tmr_load(input logic [CFG_W-1:0] c);
      logic [TB+CFG_W-1:0] w;
      w = {{TB{1'b0}}, c};
      if (w == '0) begin
         w = (TB+CFG_W)'(1);
      end
      if (w > TMAX) begin
         w = TMAX;
      end
      return w[TB-1:0];
   endfunction

   logic [SEQ_W-1:0] fseq, fack, want, fe_prev;
   logic             out_free;
   logic             emit;
   logic [2:0]       emit_act;
   logic [SEQ_W-1:0] emit_seq, emit_ack;
   logic             send_data;
   logic [SEQ_W-1:0] data_seq;
   logic [TB-1:0]    walk_tmr;
   swe_rsp_type      item;

   assign fseq     = seq_lut[req_ff.frame_seq];
   assign fack     = seq_lut[req_ff.frame_ack];
   assign want     = seq_next(fack);
   assign fe_prev  = (fe_ff == '0) ? SEQ_MAX : fe_ff - 1'b1;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign walk_tmr = timers_ff[walk_ff];

   always_comb begin
      st.can_emit     = !pend_valid_ff || out_free;
      st.flush_done   = !pend_valid_ff;
      st.deliver_more = marks_ff[slot_lut[fe_ff]];
      st.release_more = in_win(ae_ff, fack, nts_ff);
      st.tick_last    = (walk_ff == SLOT_LAST);
      st.req_type     = req_ff.req_type;
      st.frame_kind   = req_ff.frame_kind;
      st.checksum_bad = req_ff.checksum_bad;
   end

   always_comb begin
      cfg_frame_in  = cfg_frame_ff;
      cfg_ack_in    = cfg_ack_ff;
      req_in        = req_ff;
      ae_in         = ae_ff;
      nts_in        = nts_ff;
      fe_in         = fe_ff;
      tf_in         = tf_ff;
      outst_in      = outst_ff;
      nak_ok_in     = nak_ok_ff;
      marks_in      = marks_ff;
      slot_seq_in   = slot_seq_ff;
      timers_in     = timers_ff;
      ack_tmr_in    = ack_tmr_ff;
      walk_in       = walk_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      emit          = 1'b0;
      emit_act      = ACT_DATA;
      emit_seq      = '0;
      emit_ack      = fe_prev;
      send_data     = 1'b0;
      data_seq      = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_TIMEOUT: cfg_frame_in = csr_wdata;
            default:           cfg_ack_in   = csr_wdata;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (cmd.op)
         OP_LATCH: begin
            req_in  = req_data;
            walk_in = '0;
            cnt_in  = '0;
         end
         OP_TICK_SLOT: begin
            if (walk_tmr != '0) begin
               timers_in[walk_ff] = walk_tmr - 1'b1;
               if (walk_tmr == TB'(1)) begin
                  send_data = 1'b1;
                  data_seq  = slot_seq_ff[walk_ff];
               end
            end
            if (walk_ff != SLOT_LAST) begin
               walk_in = walk_ff + 1'b1;
            end
         end
         OP_TICK_ACK: begin
            if (ack_tmr_ff != '0) begin
               ack_tmr_in = ack_tmr_ff - 1'b1;
               if (ack_tmr_ff == TB'(1)) begin
                  emit     = 1'b1;
                  emit_act = ACT_ACK;
               end
            end
         end
         OP_SEND: begin
            if (outst_ff >= CNT_FULL) begin
               emit     = 1'b1;
               emit_act = ACT_REFUSE;
               emit_seq = nts_ff;
            end else begin
               outst_in  = outst_ff + 1'b1;
               send_data = 1'b1;
               data_seq  = nts_ff;
               nts_in    = seq_next(nts_ff);
            end
         end
         OP_DATA_FRONT: begin
            if (fseq != fe_ff && nak_ok_ff) begin
               emit       = 1'b1;
               emit_act   = ACT_NAK;
               nak_ok_in  = 1'b0;
               ack_tmr_in = '0;
            end else begin
               ack_tmr_in = tmr_load(cfg_ack_ff);
            end
            if (in_win(fe_ff, fseq, tf_ff)) begin
               marks_in[slot_lut[fseq]] = 1'b1;
            end
         end
         OP_DELIVER: begin
            nak_ok_in                 = 1'b1;
            marks_in[slot_lut[fe_ff]] = 1'b0;
            fe_in                     = seq_next(fe_ff);
            tf_in                     = seq_next(tf_ff);
            ack_tmr_in                = tmr_load(cfg_ack_ff);
            emit                      = 1'b1;
            emit_act                  = ACT_DELIVER;
            emit_seq                  = fe_ff;
            emit_ack                  = fe_ff;
         end
         OP_NAK_RESEND: begin
            if (in_win(ae_ff, want, nts_ff)) begin
               send_data = 1'b1;
               data_seq  = want;
            end
         end
         OP_RELEASE: begin
            if (outst_ff != '0) begin
               outst_in = outst_ff - 1'b1;
            end
            timers_in[slot_lut[ae_ff]] = '0;
            ae_in = seq_next(ae_ff);
         end
         OP_BAD_NAK: begin
            if (nak_ok_ff) begin
               emit       = 1'b1;
               emit_act   = ACT_NAK;
               nak_ok_in  = 1'b0;
               ack_tmr_in = '0;
            end
         end
         OP_SESSION: begin
            ae_in      = '0;
            nts_in     = '0;
            fe_in      = '0;
            tf_in      = TF_RST;
            outst_in   = '0;
            nak_ok_in  = 1'b1;
            marks_in   = '0;
            ack_tmr_in = '0;
            for (int i = 0; i < WINDOW; i++) begin
               timers_in[i] = '0;
            end
         end
         OP_FINISH: begin
            if (pend_valid_ff && out_free) begin
               rsp_in             = pend_ff;
               rsp_in.last_result = 1'b1;
               rsp_valid_in       = 1'b1;
               pend_valid_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // A data send reloads its slot timer and stops the ack timer.
      if (send_data) begin
         emit                          = 1'b1;
         emit_act                      = ACT_DATA;
         emit_seq                      = data_seq;
         slot_seq_in[slot_lut[data_seq]] = data_seq;
         timers_in[slot_lut[data_seq]]   = tmr_load(cfg_frame_ff);
         ack_tmr_in                    = '0;
      end
      if (emit && emit_act == ACT_ACK) begin
         ack_tmr_in = '0;
      end

      item.action      = emit_act;
      item.out_seq     = to3(emit_seq);
      item.out_ack     = to3(emit_ack);
      item.buffer_slot = to2(slot_lut[emit_seq]);
      item.last_result = 1'b0;

      // The newest word waits in the holding stage until the step shows
      // whether another follows; only then is its last flag known.
      if (emit && cnt_ff < 4'(RESULT_CAP)) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_valid_in = 1'b1;
         end
         pend_in       = item;
         pend_valid_in = 1'b1;
         cnt_in        = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_frame_ff  <= FRAME_TIMEOUT_RST;
         cfg_ack_ff    <= ACK_TIMEOUT_RST;
         ae_ff         <= '0;
         nts_ff        <= '0;
         fe_ff         <= '0;
         tf_ff         <= TF_RST;
         outst_ff      <= '0;
         nak_ok_ff     <= 1'b1;
         marks_ff      <= '0;
         ack_tmr_ff    <= '0;
         walk_ff       <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            timers_ff[i] <= '0;
         end
      end else begin
         cfg_frame_ff  <= cfg_frame_in;
         cfg_ack_ff    <= cfg_ack_in;
         ae_ff         <= ae_in;
         nts_ff        <= nts_in;
         fe_ff         <= fe_in;
         tf_ff         <= tf_in;
         outst_ff      <= outst_in;
         nak_ok_ff     <= nak_ok_in;
         marks_ff      <= marks_in;
         ack_tmr_ff    <= ack_tmr_in;
         walk_ff       <= walk_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         timers_ff     <= timers_in;
      end
      req_ff      <= req_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      slot_seq_ff <= slot_seq_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ sv/swe_ctrl.sv @@
`default_nettype none
module swe_ctrl import swe_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire swe_status_type st,
   output swe_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_TICK_SLOT,
      S_TICK_ACK,
      S_SEND,
      S_DATA_FRONT,
      S_DELIVER,
      S_NAK_RESEND,
      S_RELEASE,
      S_BAD_NAK,
      S_SESSION,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      bad_data;

   assign bad_data  = (st.frame_kind == KIND_DATA) && st.checksum_bad;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (st.req_type)
               REQ_TICK:  state_in = S_TICK_SLOT;
               REQ_SEND:  state_in = S_SEND;
               REQ_FRAME: begin
                  if (bad_data) begin
                     state_in = S_RELEASE;
                  end else if (st.frame_kind == KIND_DATA) begin
                     state_in = S_DATA_FRONT;
                  end else if (st.frame_kind == KIND_NAK) begin
                     state_in = S_NAK_RESEND;
                  end else begin
                     state_in = S_RELEASE;
                  end
               end
               default:   state_in = S_SESSION;
            endcase
         end
         S_TICK_SLOT: begin
            if (st.can_emit) begin
               cmd.op = OP_TICK_SLOT;
               if (st.tick_last) begin
                  state_in = S_TICK_ACK;
               end
            end
         end
         S_TICK_ACK: begin
            if (st.can_emit) begin
               cmd.op   = OP_TICK_ACK;
               state_in = S_FINISH;
            end
         end
         S_SEND: begin
            if (st.can_emit) begin
               cmd.op   = OP_SEND;
               state_in = S_FINISH;
            end
         end
         S_DATA_FRONT: begin
            if (st.can_emit) begin
               cmd.op   = OP_DATA_FRONT;
               state_in = S_DELIVER;
            end
         end
         S_DELIVER: begin
            if (!st.deliver_more) begin
               state_in = S_RELEASE;
            end else if (st.can_emit) begin
               cmd.op = OP_DELIVER;
            end
         end
         S_NAK_RESEND: begin
            if (st.can_emit) begin
               cmd.op   = OP_NAK_RESEND;
               state_in = S_RELEASE;
            end
         end
         S_RELEASE: begin
            if (st.release_more) begin
               cmd.op = OP_RELEASE;
            end else if (bad_data) begin
               state_in = S_BAD_NAK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_BAD_NAK: begin
            if (st.can_emit) begin
               cmd.op   = OP_BAD_NAK;
               state_in = S_FINISH;
            end
         end
         S_SESSION: begin
            cmd.op   = OP_SESSION;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.op = OP_FINISH;
            if (st.flush_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire
